// ===== rtl/baro_temp_pressure_compensation_defines.svh =====
// Assertion macros shared by the compensation block.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_DEFINES_SVH

// Checked only while reset is released.
`define BTPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BTPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/btpc_pkg.sv =====
package btpc_pkg;

  // Cycles from an accepted start to its result strobe.
  localparam int unsigned LATENCY = 9;

  localparam logic signed [19:0] TEMP_BASE = 20'sd2000;
  localparam logic signed [31:0] P_MIN     = 32'sd1000;
  localparam logic signed [31:0] P_MAX     = 32'sd120000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESSURE_SENS    = 3'd0,
    CFG_PRESSURE_OFFSET  = 3'd1,
    CFG_SENS_TEMP_COEF   = 3'd2,
    CFG_OFFSET_TEMP_COEF = 3'd3,
    CFG_REFERENCE_TEMP   = 3'd4,
    CFG_TEMP_SENS        = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] pressure_sens;
    logic [15:0] pressure_offset;
    logic [15:0] sens_temp_coef;
    logic [15:0] offset_temp_coef;
    logic [15:0] reference_temp;
    logic [15:0] temp_sens;
  } btpc_cal_t;

  typedef struct packed {
    logic [23:0] raw_temperature;
    logic [23:0] pressure_code;
  } btpc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] pressure;
    logic               out_of_range;
  } btpc_out_t;

  // First-order results handed to the correction stages.
  typedef struct packed {
    logic signed [19:0] temp;
    logic signed [18:0] d;
    logic        [18:0] t2;
    logic               low;
    logic signed [35:0] off;
    logic signed [34:0] sens;
    logic        [23:0] rp;
  } btpc_first_t;

  // Corrected values handed to the pressure stages.
  typedef struct packed {
    logic signed [20:0] temp;
    logic signed [40:0] off;
    logic signed [39:0] sens;
    logic        [23:0] rp;
  } btpc_second_t;

  // Signed shift right by sh that rounds toward zero, like a C division.
  function automatic logic signed [64:0] trunc_shr(input logic signed [64:0] x,
                                                   input int unsigned sh);
    logic signed [64:0] bias;
    bias = x[64] ? ((65'sd1 <<< sh) - 65'sd1) : 65'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

// ===== rtl/btpc_front.sv =====
module btpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  btpc_pkg::btpc_in_t   in_i,
  input  btpc_pkg::btpc_cal_t  cal_i,
  output logic                 valid_o,
  output btpc_pkg::btpc_first_t first_o
);
  import btpc_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic signed [24:0] dt_q, dt_d;
  logic        [23:0] rp1_q, rp2_q;
  logic signed [41:0] m6_q, m4_q, m3_q;
  logic signed [49:0] dd_q;
  logic signed [16:0] c6_s, c4_s, c3_s;
  logic signed [64:0] m6_ext, m4_ext, m3_ext, q6_full, q4_full, q3_full;
  logic signed [18:0] q6;
  logic signed [34:0] q4;
  logic signed [33:0] q3;
  btpc_first_t        first_d, first_q;

  assign dt_d = $signed({1'b0, in_i.raw_temperature})
              - $signed({1'b0, cal_i.reference_temp, 8'h00});

  assign c6_s = $signed({1'b0, cal_i.temp_sens});
  assign c4_s = $signed({1'b0, cal_i.offset_temp_coef});
  assign c3_s = $signed({1'b0, cal_i.sens_temp_coef});

  assign m6_ext  = 65'(m6_q);
  assign m4_ext  = 65'(m4_q);
  assign m3_ext  = 65'(m3_q);
  assign q6_full = trunc_shr(m6_ext, 23);
  assign q4_full = trunc_shr(m4_ext, 7);
  assign q3_full = trunc_shr(m3_ext, 8);
  assign q6 = q6_full[18:0];
  assign q4 = q4_full[34:0];
  assign q3 = q3_full[33:0];

  always_comb begin
    first_d.temp = TEMP_BASE + 20'(q6);
    first_d.d    = q6;
    first_d.low  = q6[18];
    first_d.t2   = dd_q[49:31];
    first_d.off  = $signed({4'b0000, cal_i.pressure_offset, 16'h0000}) + 36'(q4);
    first_d.sens = $signed({4'b0000, cal_i.pressure_sens, 15'h0000}) + 35'(q3);
    first_d.rp   = rp2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    rp1_q   <= in_i.pressure_code;
    m6_q    <= dt_q * c6_s;
    m4_q    <= dt_q * c4_s;
    m3_q    <= dt_q * c3_s;
    dd_q    <= dt_q * dt_q;
    rp2_q   <= rp1_q;
    first_q <= first_d;
  end

  assign valid_o = v3_q;
  assign first_o = first_q;

endmodule

// ===== rtl/btpc_second.sv =====
module btpc_second (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  btpc_pkg::btpc_first_t  first_i,
  output logic                   valid_o,
  output btpc_pkg::btpc_second_t second_o
);
  import btpc_pkg::*;

  logic               v4_q, v5_q;
  logic        [37:0] dsq_q;
  btpc_first_t        first_q;
  logic        [40:0] five_sq;
  logic        [39:0] off2;
  logic        [38:0] sens2;
  btpc_second_t       second_d, second_q;

  // 5 * d^2 as a shift and add; both corrections are positive, so plain shifts divide.
  assign five_sq = {3'b000, dsq_q} + {1'b0, dsq_q, 2'b00};
  assign off2    = five_sq[40:1];
  assign sens2   = five_sq[40:2];

  always_comb begin
    second_d.rp = first_q.rp;
    if (first_q.low) begin
      second_d.temp = 21'(first_q.temp) - $signed({2'b00, first_q.t2});
      second_d.off  = 41'(first_q.off) - $signed({1'b0, off2});
      second_d.sens = 40'(first_q.sens) - $signed({1'b0, sens2});
    end else begin
      second_d.temp = 21'(first_q.temp);
      second_d.off  = 41'(first_q.off);
      second_d.sens = 40'(first_q.sens);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dsq_q    <= first_i.d * first_i.d;
    first_q  <= first_i;
    second_q <= second_d;
  end

  assign valid_o  = v5_q;
  assign second_o = second_q;

endmodule

// ===== rtl/btpc_press.sv =====
module btpc_press (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  btpc_pkg::btpc_second_t second_i,
  output logic                   valid_o,
  output btpc_pkg::btpc_out_t    result_o
);
  import btpc_pkg::*;

  logic               v6_q, v7_q, v8_q, v9_q;
  logic        [43:0] pl_q;
  logic signed [44:0] ph_q;
  logic signed [64:0] prod_q;
  logic signed [44:0] a_q;
  logic signed [40:0] off6_q, off7_q;
  logic signed [20:0] temp6_q, temp7_q, temp8_q;
  logic signed [19:0] sens_hi;
  logic signed [64:0] q2_full, a_ext, p_full;
  logic signed [31:0] p32;
  btpc_out_t          res_d, res_q;

  // raw_pressure * sens is split into two partial products on the low and high sens halves.
  assign sens_hi = second_i.sens[39:20];

  assign q2_full = trunc_shr(prod_q, 21);
  assign a_ext   = 65'(a_q);
  assign p_full  = trunc_shr(a_ext, 15);
  assign p32     = 32'($signed(p_full[29:0]));

  always_comb begin
    res_d.temperature  = 32'(temp8_q);
    res_d.pressure     = p32;
    res_d.out_of_range = (p32 < P_MIN) || (p32 > P_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v6_q <= valid_i;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q    <= second_i.rp * second_i.sens[19:0];
    ph_q    <= $signed({1'b0, second_i.rp}) * sens_hi;
    off6_q  <= second_i.off;
    temp6_q <= second_i.temp;
    prod_q  <= (65'(ph_q) <<< 20) + $signed({21'd0, pl_q});
    off7_q  <= off6_q;
    temp7_q <= temp6_q;
    a_q     <= 45'($signed(q2_full[43:0])) - 45'(off7_q);
    temp8_q <= temp7_q;
    res_q   <= res_d;
  end

  assign valid_o  = v9_q;
  assign result_o = res_q;

endmodule

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation. A transaction is taken
// on every clock edge with start high; busy never rises, so one sample per
// cycle can be fed. The result leaves the nine-stage multiplier pipeline,
// whose widest product is cut into two partial products, on result_o with
// result_valid_o high for exactly one cycle, and cannot be held off: latch
// it when the strobe is seen. Calibration registers are written through the
// cfg port and must only change while no transaction is in flight.
module baro_temp_pressure_compensation (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  btpc_pkg::btpc_in_t                     in_i,
  output logic                                   result_valid_o,
  output btpc_pkg::btpc_out_t                    result_o,
  input  logic                                   cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [btpc_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);
  import btpc_pkg::*;

  `include "baro_temp_pressure_compensation_defines.svh"

  btpc_cal_t    cal_q, cal_d;
  logic         accept;
  logic         front_valid, second_valid;
  btpc_first_t  first;
  btpc_second_t second;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESSURE_SENS:    cal_d.pressure_sens    = cfg_wdata_i;
        CFG_PRESSURE_OFFSET:  cal_d.pressure_offset  = cfg_wdata_i;
        CFG_SENS_TEMP_COEF:   cal_d.sens_temp_coef   = cfg_wdata_i;
        CFG_OFFSET_TEMP_COEF: cal_d.offset_temp_coef = cfg_wdata_i;
        CFG_REFERENCE_TEMP:   cal_d.reference_temp   = cfg_wdata_i;
        CFG_TEMP_SENS:        cal_d.temp_sens        = cfg_wdata_i;
        default:              cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  btpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .cal_i   (cal_q),
    .valid_o (front_valid),
    .first_o (first)
  );

  btpc_second u_second (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (front_valid),
    .first_i  (first),
    .valid_o  (second_valid),
    .second_o (second)
  );

  btpc_press u_press (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (second_valid),
    .second_i (second),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  `BTPC_ASSERT(a_result_latency, clk_i, rst_ni,
    result_valid_o |-> $past(start, LATENCY),
    "result strobe without a transaction taken nine cycles earlier")

  `BTPC_ASSERT(a_temp_range, clk_i, rst_ni,
    result_valid_o |-> (result_o.temperature >= -32'sd1048576 &&
                        result_o.temperature < 32'sd1048576),
    "temperature result exceeds its internal width")

  `BTPC_ASSERT(a_cfg_write, clk_i, rst_ni,
    (cfg_we_i && cfg_idx_i == CFG_TEMP_SENS) |=> (cal_q.temp_sens == $past(cfg_wdata_i)),
    "temperature coefficient write was lost")

  // The strobe flop is only known to be clear once a reset edge has been seen.
  `BTPC_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |=> !result_valid_o,
    "result strobe following a reset cycle")

endmodule

// ===== tb/baro_temp_pressure_compensation_tb.sv =====
module baro_temp_pressure_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btpc_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_SAMPLES = 180;

  // Register indexes that the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  btpc_in_t in_i = '0;
  logic result_valid_o;
  btpc_out_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  btpc_cal_t cal_shadow = '0;
  btpc_out_t comp_results_due[$];
  int unsigned idle_pct = 0;

  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_cold = 0;
  int unsigned n_flagged = 0;
  int unsigned n_settings = 0;
  int unsigned quiet_cycles = 0;

  baro_temp_pressure_compensation i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Second-order compensation in 64-bit signed arithmetic; SystemVerilog
  // division truncates toward zero just like the sensor's formulas assume.
  function automatic btpc_out_t compensate(input btpc_cal_t cal, input btpc_in_t smp);
    longint raw_t, raw_p, dt, temp, off, sens, t2, d, p;
    logic signed [31:0] p_lo;
    btpc_out_t res;
    raw_t = longint'(smp.raw_temperature);
    raw_p = longint'(smp.pressure_code);
    dt = raw_t - longint'(cal.reference_temp) * 256;
    temp = longint'(TEMP_BASE) + dt * longint'(cal.temp_sens) / 8388608;
    off = longint'(cal.pressure_offset) * 65536 + longint'(cal.offset_temp_coef) * dt / 128;
    sens = longint'(cal.pressure_sens) * 32768 + longint'(cal.sens_temp_coef) * dt / 256;
    t2 = 0;
    if (temp < longint'(TEMP_BASE)) begin
      d = temp - longint'(TEMP_BASE);
      t2 = dt * dt / 64'sd2147483648;
      off -= 5 * (d * d) / 2;
      sens -= 5 * (d * d) / 4;
    end
    p = (raw_p * sens / 2097152 - off) / 32768;
    p_lo = p[31:0];
    res.temperature = 32'(temp - t2);
    res.pressure = p_lo;
    res.out_of_range = (p_lo < P_MIN) || (p_lo > P_MAX);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (n_errors < MAX_REPORTS) begin
      $display("%0t: result %0d, %s expected %0d, got %0d", $realtime, n_checked, what,
               want, got);
    end
    n_errors++;
  endtask

  // Result checker and watchdog. Results cannot be held off, so every strobe
  // is a transaction.
  always @(posedge clk_i) begin
    btpc_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no activity for %0d cycles, %0d results outstanding", $realtime,
                 STALL_LIMIT, comp_results_due.size());
        $display("** baro_temp_pressure_compensation: FAILED **");
        $finish;
      end
      if (result_valid_o) begin
        if (comp_results_due.size() == 0) begin
          report_mismatch("unexpected strobe, temperature", 0, result_o.temperature);
        end else begin
          want = comp_results_due.pop_front();
          if (result_o.temperature !== want.temperature) begin
            report_mismatch("temperature", want.temperature, result_o.temperature);
          end
          if (result_o.pressure !== want.pressure) begin
            report_mismatch("pressure", want.pressure, result_o.pressure);
          end
          if (result_o.out_of_range !== want.out_of_range) begin
            report_mismatch("out_of_range", want.out_of_range, result_o.out_of_range);
          end
          if (want.temperature < TEMP_BASE) n_cold++;
          if (want.out_of_range) n_flagged++;
        end
        n_checked++;
      end
    end
  end

  // Sends one sample, with an optional idle gap in front of it, and records
  // the expected result once the block has taken the transaction.
  task automatic send_sample(input logic [23:0] raw_t, input logic [23:0] raw_p);
    btpc_in_t smp;
    smp.raw_temperature = raw_t;
    smp.pressure_code = raw_p;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i <= smp;
    do @(posedge clk_i); while (busy);
    comp_results_due.push_back(compensate(cal_shadow, smp));
    n_sent++;
  endtask

  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (cfg_idx_e'(idx))
      CFG_PRESSURE_SENS:    cal_shadow.pressure_sens = val;
      CFG_PRESSURE_OFFSET:  cal_shadow.pressure_offset = val;
      CFG_SENS_TEMP_COEF:   cal_shadow.sens_temp_coef = val;
      CFG_OFFSET_TEMP_COEF: cal_shadow.offset_temp_coef = val;
      CFG_REFERENCE_TEMP:   cal_shadow.reference_temp = val;
      CFG_TEMP_SENS:        cal_shadow.temp_sens = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(input btpc_cal_t cal);
    write_cal(CFG_PRESSURE_SENS, cal.pressure_sens);
    write_cal(CFG_PRESSURE_OFFSET, cal.pressure_offset);
    write_cal(CFG_SENS_TEMP_COEF, cal.sens_temp_coef);
    write_cal(CFG_OFFSET_TEMP_COEF, cal.offset_temp_coef);
    write_cal(CFG_REFERENCE_TEMP, cal.reference_temp);
    write_cal(CFG_TEMP_SENS, cal.temp_sens);
    n_settings++;
  endtask

  // Stops sending and waits for every outstanding result, so the block is idle.
  task automatic drain;
    @(negedge clk_i);
    start <= 1'b0;
    while (comp_results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset_values;
    idle_pct = 0;
    n_settings++;
    send_sample(24'd0, 24'd0);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    drain();
  endtask

  task automatic test_nominal_calibration;
    logic [23:0] ref_t;
    load_cal('{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312});
    ref_t = {cal_shadow.reference_temp, 8'd0};
    send_sample(24'd9085466, 24'd8077636);
    send_sample(ref_t, 24'd4000000);
    send_sample(ref_t - 24'd1, 24'd6000000);
    send_sample(ref_t + 24'd1, 24'd0);
    // Below 20 degrees, then far below -15 degrees.
    send_sample(ref_t - 24'd262144, 24'd8077636);
    send_sample(ref_t - 24'd4194304, 24'd5000000);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd3000000);
    drain();
  endtask

  task automatic test_unused_register_index;
    write_cal(CFG_IDX_SPARE_LO, 16'hFFFF);
    write_cal(CFG_IDX_SPARE_HI, 16'h5A5A);
    send_sample(24'd8500000, 24'd8077636);
    send_sample(24'd8700000, 24'd7000000);
    drain();
  endtask

  task automatic test_extreme_calibration;
    load_cal('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_sample(24'd0, 24'd0);
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'd0);
    drain();
    // No reference offset, so the temperature difference is never negative and is large for high raw values.
    load_cal('{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF});
    send_sample(24'd0, 24'hFFFFFF);
    send_sample(24'hFFFFFF, 24'hFFFFFF);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'hFFFFFF, 24'd1);
    drain();
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic test_random_samples;
    btpc_cal_t cal;
    int ref_t;
    int t_val;
    logic [23:0] raw_t, raw_p;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      cal.pressure_sens = rand_coef();
      cal.pressure_offset = rand_coef();
      cal.sens_temp_coef = rand_coef();
      cal.offset_temp_coef = rand_coef();
      cal.reference_temp = rand_coef();
      cal.temp_sens = rand_coef();
      load_cal(cal);
      write_cal($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI, rand_coef());
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 47;
        default: idle_pct = 7;
      endcase
      ref_t = int'(cal_shadow.reference_temp) * 256;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // A quarter of the samples sit near the reference temperature, where the
        // first and second order branches meet.
        case ($urandom_range(0, 3))
          0: t_val = $urandom_range(0, 24'hFFFFFF);
          1: t_val = ref_t + int'($urandom_range(0, 131072)) - 65536;
          2: t_val = ref_t - int'($urandom_range(0, 2097152));
          default: t_val = $urandom_range(0, 1) ? 24'hFFFFFF : 0;
        endcase
        raw_t = t_val[23:0];
        case ($urandom_range(0, 7))
          0: raw_p = 24'd0;
          1: raw_p = 24'hFFFFFF;
          default: raw_p = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        send_sample(raw_t, raw_p);
      end
      drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_nominal_calibration();
    test_unused_register_index();
    test_extreme_calibration();
    test_random_samples();
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Sent %0d samples under %0d calibration settings, checked %0d results.",
             n_sent, n_settings, n_checked);
    $display("%0d results were below 20.00 degrees and %0d had the pressure flag set.",
             n_cold, n_flagged);
    if (n_errors == 0 && n_checked == n_sent) begin
      $display("** baro_temp_pressure_compensation: PASSED **");
    end else begin
      $display("%0d mismatches, %0d samples sent, %0d results seen", n_errors, n_sent,
               n_checked);
      $display("** baro_temp_pressure_compensation: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/btpc_pkg.sv
rtl/btpc_front.sv
rtl/btpc_second.sv
rtl/btpc_press.sv
rtl/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
